// ===== rtl/core/hhti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hhti_pkg;

	localparam int WORD_W     = 32;
	localparam int COUNT_W    = 3;
	localparam int WORD_BYTES = 4;
	localparam int BYTE_BITS  = 8;
	localparam int STEP_W     = $clog2(WORD_W);

	localparam logic [WORD_W-1:0] SUM_MUL   = 32'd3;
	localparam logic [WORD_W-1:0] WORD_MUL  = 32'd5;
	localparam logic [WORD_W-1:0] ADD_CONST = 32'd1999;
	localparam logic [WORD_W-1:0] TSIZE_RST = 32'd1;

	localparam logic [COUNT_W-1:0] COUNT_EMPTY = 3'd0;
	localparam logic [COUNT_W-1:0] COUNT_FULL  = 3'(WORD_BYTES);

	typedef struct packed {
		logic load;
		logic sel_seed;
		logic mix;
		logic div_step;
		logic out_load;
		logic err;
	} hhti_cmd_t;

	typedef struct packed {
		logic tsize_zero;
		logic div_last;
	} hhti_sts_t;

	// tail bytes packed with the first byte most significant
	function automatic logic [WORD_W-1:0] pack_tail(input logic [WORD_W-1:0] chunk,
			input logic [COUNT_W-1:0] count);
		logic [WORD_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < WORD_BYTES - 1; i++) begin
			if (COUNT_W'(i) < count) begin
				acc = (acc << BYTE_BITS) | WORD_W'(chunk[i*BYTE_BITS +: BYTE_BITS]);
			end
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hhti_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hhti_dp
	import hhti_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [2*WORD_W-1:0]    s_tdata,
	input  wire logic [COUNT_W-1:0]     s_count,
	input  wire logic                   cfg_valid,
	input  wire logic [WORD_W-1:0]      cfg_data,
	input  wire hhti_cmd_t              cmd,
	output hhti_sts_t                   sts,
	output logic [WORD_W-1:0]           bucket,
	output logic                        framing_error
);

	logic [WORD_W-1:0] tsize_q;
	logic [WORD_W-1:0] sum_q;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] dvd_q;
	logic [WORD_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic [WORD_W-1:0] bucket_q;
	logic              err_q;

	logic [WORD_W-1:0] chunk;
	logic [WORD_W-1:0] seed;
	logic [WORD_W-1:0] mixed;
	logic [WORD_W:0]   rem_shift;
	logic [WORD_W:0]   rem_diff;
	logic [WORD_W-1:0] rem_next;

	assign chunk = s_tdata[WORD_W-1:0];
	assign seed  = s_tdata[2*WORD_W-1:WORD_W];

	assign mixed = SUM_MUL * sum_q + WORD_MUL * word_q + ADD_CONST;

	// one restoring step of the remainder
	assign rem_shift = {rem_q, dvd_q[WORD_W-1]};
	assign rem_diff  = rem_shift - {1'b0, tsize_q};
	assign rem_next  = rem_diff[WORD_W] ? rem_shift[WORD_W-1:0] : rem_diff[WORD_W-1:0];

	assign sts.tsize_zero = (tsize_q == '0);
	assign sts.div_last   = (step_q == STEP_W'(WORD_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= TSIZE_RST;
			step_q  <= '0;
		end else begin
			if (cfg_valid) begin
				tsize_q <= cfg_data;
			end
			if (cmd.mix) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (cmd.sel_seed) begin
				sum_q <= seed;
			end
			word_q <= (s_count >= COUNT_FULL) ? chunk : pack_tail(chunk, s_count);
		end
		if (cmd.mix) begin
			sum_q <= mixed;
			dvd_q <= mixed;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_next;
			if (sts.div_last) begin
				sum_q <= rem_next;
			end
		end
		if (cmd.out_load) begin
			bucket_q <= sum_q;
			err_q    <= cmd.err;
		end
	end

	assign bucket        = bucket_q;
	assign framing_error = err_q;

endmodule

`default_nettype wire

// ===== rtl/core/hhti_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hhti_ctrl
	import hhti_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic               s_tlast,
	input  wire logic [COUNT_W-1:0] s_count,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output hhti_cmd_t               cmd,
	input  wire hhti_sts_t          sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MIX,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   inside_q;
	logic   need_out_q;
	logic   err_q;
	logic   out_valid_q;

	logic accept;
	logic slot_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.sel_seed = !inside_q;
		cmd.mix      = (state_q == ST_MIX);
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_FINISH) && slot_free;
		cmd.err      = err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inside_q    <= 1'b0;
			need_out_q  <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !cmd.out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_count == COUNT_EMPTY) begin
							err_q    <= !s_tlast;
							inside_q <= 1'b0;
							state_q  <= ST_FINISH;
						end else if (s_count >= COUNT_FULL) begin
							need_out_q <= s_tlast;
							err_q      <= 1'b0;
							inside_q   <= !s_tlast;
							state_q    <= ST_MIX;
						end else begin
							need_out_q <= 1'b1;
							err_q      <= !s_tlast;
							inside_q   <= 1'b0;
							state_q    <= ST_MIX;
						end
					end
				end
				ST_MIX: begin
					if (!sts.tsize_zero) begin
						state_q <= ST_DIV;
					end else if (need_out_q) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= need_out_q ? ST_FINISH : ST_IDLE;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_empty_goes_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (s_count == COUNT_EMPTY) |=> state_q == ST_FINISH)
		else $error("empty key did not go straight to output");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result load did not raise output valid");

	a_mid_key_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && sts.div_last && !need_out_q |=> state_q == ST_IDLE)
		else $error("chunk inside a key produced an output");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) && out_valid_q && !m_tready |=> state_q == ST_FINISH)
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== rtl/core/handle_hash_table_index_core.sv =====
// Bucket index hash for file-handle keys.
//
// Input stream (s_*): one request per 32-bit key chunk. s_tdata carries the
// chunk in bits 31:0 and the seed in bits 63:32; s_tuser is the byte count
// (4 or more full word, 1-3 tail, 0 end of key); s_tlast marks the last chunk.
// The seed is used only on the first chunk of a key.
// Output stream (m_*): one request per finished key. m_tdata is the bucket,
// m_tuser[0] flags a short or empty chunk that arrived without tlast.
// Config channel (cfg_*): table size, always ready; write only while idle.
//
// Each chunk with bytes is accepted, then the sum is updated, then the
// 32 steps of the radix-2 restoring remainder unit run; no new chunk is
// accepted until they are done. A chunk that ends a key then loads the
// output register. An empty key goes straight to the output register; a
// table size of zero skips the remainder unit. The output register lets
// the next chunk be accepted while a result waits; a finished result
// holds until m_tready.
// Reset sets the table size to 1 and waits for the first chunk of a key.
`timescale 1ns / 1ps
`default_nettype none

module handle_hash_table_index_core
	import hhti_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [2*WORD_W-1:0] s_tdata,   // chunk, seed
	input  wire logic [COUNT_W-1:0]  s_tuser,   // byte_count
	input  wire logic                s_tlast,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [WORD_W-1:0]        m_tdata,   // bucket
	output logic [0:0]               m_tuser,   // framing_error
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [WORD_W-1:0]   cfg_data
);

	hhti_cmd_t cmd;
	hhti_sts_t sts;
	logic      framing_error;

	assign cfg_ready  = 1'b1;
	assign m_tuser[0] = framing_error;

	hhti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.s_count  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	hhti_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tdata       (s_tdata),
		.s_count       (s_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.bucket        (m_tdata),
		.framing_error (framing_error)
	);

endmodule

`default_nettype wire

// ===== bench/handle_hash_table_index_core_test.sv =====
`timescale 1ns / 1ps

module handle_hash_table_index_core_test;
	import hhti_pkg::*;

	localparam int          CLK_HALF      = 6;
	localparam int          SETTLE_CYCLES = 48;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned RANDOM_CHUNKS = 400;
	localparam int unsigned FULL_BYTES    = 4;
	localparam int unsigned REPORT_CAP    = 40;

	localparam logic [WORD_W-1:0] HASH_SUM_MUL  = 32'd3;
	localparam logic [WORD_W-1:0] HASH_WORD_MUL = 32'd5;
	localparam logic [WORD_W-1:0] HASH_OFFSET   = 32'd1999;

	typedef struct packed {
		logic [WORD_W-1:0] bucket;
		logic              framing_error;
	} bucket_result_t;

	class bucket_scoreboard;
		logic [WORD_W-1:0] table_size;
		logic [WORD_W-1:0] running_sum;
		bit                inside_key;
		bucket_result_t    expected_q[$];
		int unsigned       mismatches;
		int unsigned       chunks;
		int unsigned       keys;
		int unsigned       framing_errors;

		function new();
			table_size     = TSIZE_RST;
			running_sum    = '0;
			inside_key     = 1'b0;
			mismatches     = 0;
			chunks         = 0;
			keys           = 0;
			framing_errors = 0;
		endfunction

		function logic [WORD_W-1:0] mix_word(logic [WORD_W-1:0] sum, logic [WORD_W-1:0] word);
			logic [WORD_W-1:0] v;
			v = HASH_SUM_MUL * sum + HASH_WORD_MUL * word + HASH_OFFSET;
			if (table_size == '0) begin
				return v;
			end
			return v % table_size;
		endfunction

		// first byte of the tail ends up most significant
		function logic [WORD_W-1:0] tail_word(logic [WORD_W-1:0] chunk, int unsigned n);
			logic [WORD_W-1:0] acc;
			acc = '0;
			for (int i = 0; i < n; i++) begin
				acc = {acc[WORD_W-9:0], chunk[i*8 +: 8]};
			end
			return acc;
		endfunction

		function void note_chunk(logic [WORD_W-1:0] chunk, logic [COUNT_W-1:0] count,
				logic last, logic [WORD_W-1:0] seed);
			logic [WORD_W-1:0] sum;
			bucket_result_t    res;
			int unsigned       n;
			chunks++;
			sum = inside_key ? running_sum : seed;
			n = (count > FULL_BYTES) ? FULL_BYTES : count;
			if (n == FULL_BYTES) begin
				sum = mix_word(sum, chunk);
				if (!last) begin
					running_sum = sum;
					inside_key  = 1'b1;
					return;
				end
				res.framing_error = 1'b0;
			end else begin
				if (n != 0) begin
					sum = mix_word(sum, tail_word(chunk, n));
				end
				res.framing_error = !last;
			end
			running_sum = sum;
			inside_key  = 1'b0;
			res.bucket  = sum;
			expected_q.push_back(res);
			keys++;
			if (res.framing_error) begin
				framing_errors++;
			end
		endfunction

		function void check_result(logic [WORD_W-1:0] bucket, logic framing_error);
			bucket_result_t want;
			if (expected_q.size() == 0) begin
				if (mismatches < REPORT_CAP) begin
					$display("%0t: unexpected result, expected none, actual bucket %h error %b",
						$time, bucket, framing_error);
				end
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			if (bucket !== want.bucket) begin
				if (mismatches < REPORT_CAP) begin
					$display("%0t: bucket mismatch, expected %h actual %h",
						$time, want.bucket, bucket);
				end
				mismatches++;
			end
			if (framing_error !== want.framing_error) begin
				if (mismatches < REPORT_CAP) begin
					$display("%0t: framing_error mismatch, expected %b actual %b",
						$time, want.framing_error, framing_error);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [2*WORD_W-1:0] s_tdata   = '0;
	logic [COUNT_W-1:0]  s_tuser   = '0;
	logic                s_tlast   = 1'b0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [WORD_W-1:0]   m_tdata;
	logic [0:0]          m_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [WORD_W-1:0]   cfg_data  = '0;

	bucket_scoreboard sb;
	int unsigned      cycle_count = 0;
	int unsigned      burst_left  = 0;
	bit               gaps_on     = 1'b1;
	int unsigned      sizes_used  = 0;
	logic [15:0]      ready_pattern = 16'hFFFF;
	int unsigned      pattern_age   = 0;

	handle_hash_table_index_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, sb.expected_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver stall pattern, reloaded now and then
	always @(posedge clk) begin
		if (pattern_age == 0) begin
			case ($urandom_range(0, 3))
				0: begin
					ready_pattern <= '1;
				end
				1: begin
					ready_pattern <= 16'($urandom) | 16'h8421;
				end
				default: begin
					ready_pattern <= 16'($urandom);
				end
			endcase
			pattern_age <= $urandom_range(40, 200);
		end else begin
			ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
			pattern_age   <= pattern_age - 1;
		end
		m_tready <= ready_pattern[0];
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata, m_tuser[0]);
			end
			if (s_tvalid && s_tready) begin
				sb.note_chunk(s_tdata[WORD_W-1:0], s_tuser, s_tlast, s_tdata[2*WORD_W-1:WORD_W]);
			end
			if (cfg_valid && cfg_ready) begin
				sb.table_size = cfg_data;
			end
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic send_chunk(input logic [WORD_W-1:0] chunk, input logic [COUNT_W-1:0] count,
			input logic last, input logic [WORD_W-1:0] seed);
		int unsigned gap;
		if (gaps_on && burst_left == 0) begin
			gap        = $urandom_range(1, 9);
			burst_left = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left != 0) begin
			burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {seed, chunk};
		s_tuser  <= count;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// hold the sender until every pending bucket has come back
	task automatic drain(input int unsigned settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_table_size(input logic [WORD_W-1:0] value);
		drain(SETTLE_CYCLES);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sizes_used++;
	endtask

	task automatic send_random_key();
		int unsigned      words;
		int unsigned      pick;
		logic [WORD_W-1:0] seed;
		seed  = rand_word();
		words = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		repeat (words) begin
			send_chunk(rand_word(), COUNT_FULL, 1'b0, seed);
			seed = $urandom;
		end
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			send_chunk(rand_word(), COUNT_FULL, 1'b1, seed);
		end else if (pick < 72) begin
			send_chunk(rand_word(), COUNT_W'($urandom_range(1, 3)), 1'b1, seed);
		end else if (pick < 82) begin
			send_chunk(rand_word(), COUNT_EMPTY, 1'b1, seed);
		end else if (pick < 90) begin
			// short chunk without tlast
			send_chunk(rand_word(), COUNT_W'($urandom_range(1, 3)), 1'b0, seed);
		end else if (pick < 94) begin
			send_chunk(rand_word(), COUNT_EMPTY, 1'b0, seed);
		end else begin
			// oversized byte count acts as a full word
			send_chunk(rand_word(), COUNT_W'($urandom_range(5, 7)), 1'($urandom), seed);
		end
	endtask

	initial begin
		logic [WORD_W-1:0] phase_sizes[8];
		int unsigned       target;
		sb = new();
		phase_sizes[0] = 32'd1;
		phase_sizes[1] = 32'd2;
		phase_sizes[2] = 32'($urandom_range(3, 1000));
		phase_sizes[3] = $urandom;
		phase_sizes[4] = 32'hFFFF_FFFF;
		phase_sizes[5] = 32'd0;
		phase_sizes[6] = 32'h8000_0000;
		phase_sizes[7] = 32'd1000003;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table size still at its reset value
		send_chunk(32'h1234_5678, COUNT_EMPTY, 1'b1, 32'hFFFF_FFFF);
		send_chunk(32'hFFFF_FFFF, COUNT_FULL, 1'b1, 32'hFFFF_FFFF);

		write_table_size(32'hFFFF_FFFF);
		send_chunk(32'h0000_0000, COUNT_EMPTY, 1'b1, 32'hDEAD_BEEF);
		send_chunk(32'hFFFF_FFFF, COUNT_EMPTY, 1'b0, 32'h0000_0000);
		send_chunk(32'h0000_0000, COUNT_FULL, 1'b1, 32'h0000_0000);
		send_chunk(32'hFFFF_FFFF, COUNT_FULL, 1'b1, 32'hFFFF_FFFF);
		send_chunk(32'hFFFF_FF80, 3'd1, 1'b1, 32'h0102_0304);
		send_chunk(32'h5A5A_C3A5, 3'd2, 1'b1, 32'hFFFF_FFFF);
		send_chunk(32'h8000_0001, 3'd3, 1'b1, 32'h7FFF_FFFF);
		send_chunk(32'hFFFF_FFFF, 3'd3, 1'b0, 32'h0000_0001);
		send_chunk(32'h0403_0201, COUNT_FULL, 1'b0, 32'h8000_0000);
		send_chunk(32'h0807_0605, COUNT_FULL, 1'b1, 32'hFFFF_FFFF);
		send_chunk(32'hFFFF_FFFF, COUNT_FULL, 1'b0, 32'h0000_0000);
		send_chunk(32'h0000_0000, COUNT_EMPTY, 1'b1, 32'hFFFF_FFFF);
		send_chunk(32'hCAFE_F00D, COUNT_FULL, 1'b0, 32'h1111_1111);
		send_chunk(32'h0000_0000, COUNT_EMPTY, 1'b0, 32'h2222_2222);
		send_chunk(32'h1357_9BDF, 3'd5, 1'b1, 32'h0000_0000);
		send_chunk(32'h2468_ACE0, 3'd7, 1'b0, 32'hFFFF_FFFF);
		send_chunk(32'hFFFF_FFFF, 3'd6, 1'b1, 32'h0000_0000);

		// no reduction at all
		write_table_size(32'd0);
		send_chunk(32'hFFFF_FFFF, COUNT_FULL, 1'b1, 32'hFFFF_FFFF);
		send_chunk(32'h0000_ABCD, 3'd2, 1'b1, 32'h8765_4321);

		write_table_size(32'd7);
		send_chunk(32'h0102_0304, COUNT_FULL, 1'b0, 32'hFFFF_FFFF);
		send_chunk(32'h00C0_FFEE, 3'd3, 1'b1, 32'h0000_0000);

		target = sb.chunks;
		foreach (phase_sizes[p]) begin
			write_table_size(phase_sizes[p]);
			gaps_on = ($urandom_range(0, 3) != 0);
			target += RANDOM_CHUNKS / 8;
			while (sb.chunks < target) begin
				send_random_key();
				if ($urandom_range(0, 24) == 0) begin
					drain(1);
				end
			end
		end

		drain(SETTLE_CYCLES);
		$display("run covered %0d chunk requests, %0d keys ended, %0d with framing errors",
			sb.chunks, sb.keys, sb.framing_errors);
		$display("table sizes written: %0d, including 0, 1 and all ones", sizes_used);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/hhti_pkg.sv
rtl/core/hhti_dp.sv
rtl/core/hhti_ctrl.sv
rtl/core/handle_hash_table_index_core.sv
bench/handle_hash_table_index_core_test.sv
